// ----- hw/rtl/kvt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes of the key-value table.
// Depends on nothing; key_value_table and kvt_cell use it.
package kvt_pkg;

	// Operation codes carried on the request channel.
	typedef enum logic [1:0] {
		FUNC_SET    = 2'd0,
		FUNC_GET    = 2'd1,
		FUNC_DELETE = 2'd2,
		FUNC_LIST   = 2'd3
	} func_t;

	// Status codes carried on the response channel.
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_FULL      = 2'd2,
		STATUS_EMPTY     = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LIST
	} state_t;

	// Commands broadcast from the sequencer to every cell of the row.
	typedef struct packed {
		logic upd;        // set: overwrite the entry whose key matches
		logic append;     // set: write the new entry into the first free slot
		logic del;        // delete: matching cell takes the tail entry
		logic list_load;  // list: each cell copies its entry into its chain stage
		logic list_shift; // list: chain moves one cell towards slot zero
	} cell_cmd_t;

	localparam int SlotBits  = 6;
	localparam int CountBits = 7;

endpackage

// ----- hw/rtl/kvt_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the key-value table: requests and responses.
// Depends on nothing; the top level uses both.
interface kvt_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [63:0]        key;
	logic signed [31:0] value;
	logic [31:0]        now;

	modport source (output valid, func, key, value, now, input ready);
	modport sink   (input valid, func, key, value, now, output ready);
endinterface

interface kvt_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] result_value;
	logic [5:0]         slot;
	logic [31:0]        stamp;
	logic [63:0]        result_key;
	logic [6:0]         count;
	logic               last;

	modport source (output valid, status, result_value, slot, stamp, result_key, count, last,
		input ready);
	modport sink   (input valid, status, result_value, slot, stamp, result_key, count, last,
		output ready);
endinterface

// ----- hw/rtl/key_value_table.sv -----
`timescale 1ns / 1ps
// Key-value table of up to CAPACITY entries, held in a row of cells, one slot per cell.
// Set, get and delete are accepted in idle; then, in the exec state, every cell compares
// its key with the request at once, and the update is committed together with the
// response once the output register is free. List loads the read-out chain in exec, then
// shifts out one live entry per cycle via slot zero while the output register is free.
// A new item is accepted once the sequencer is back in idle; a finished response waits in
// the output register and does not hold up the next acceptance. Live entries always fill
// slots zero to count minus one, since delete moves the tail entry into the freed slot.
// Depends on kvt_pkg, kvt_req_if, kvt_rsp_if and kvt_cell.
module key_value_table #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 64
) (
	input logic     clk,
	input logic     arst_n,
	kvt_req_if.sink   req,
	kvt_rsp_if.source rsp
);

	localparam logic [kvt_pkg::CountBits-1:0] CapCount = kvt_pkg::CountBits'(CAPACITY);

	kvt_pkg::state_t state_q, state_d;
	logic [kvt_pkg::CountBits-1:0] count_q, count_d;
	logic [kvt_pkg::SlotBits-1:0]  list_idx_q, list_idx_d;

	// Request registers.
	kvt_pkg::func_t      func_q;
	logic [KEY_BITS-1:0] key_q;
	logic signed [31:0]  value_q;
	logic [31:0]         now_q;

	// Output register.
	logic                          out_valid_q;
	kvt_pkg::status_t              out_status_q, out_status_d;
	logic signed [31:0]            out_value_q, out_value_d;
	logic [kvt_pkg::SlotBits-1:0]  out_slot_q, out_slot_d;
	logic [31:0]                   out_stamp_q, out_stamp_d;
	logic [63:0]                   out_key_q, out_key_d;
	logic [kvt_pkg::CountBits-1:0] out_count_q, out_count_d;
	logic                          out_last_q, out_last_d;
	logic                          out_load;
	logic                          out_free;

	kvt_pkg::cell_cmd_t cmd;
	logic               accept;
	logic               list_end;

	// Cell row signals.
	logic [CAPACITY-1:0] hit_vec;
	logic [CAPACITY-1:0] tail_vec;
	logic [KEY_BITS-1:0] ent_key   [CAPACITY];
	logic signed [31:0]  ent_value [CAPACITY];
	logic [31:0]         ent_stamp [CAPACITY];
	logic [KEY_BITS-1:0] ch_key    [CAPACITY+1];
	logic signed [31:0]  ch_value  [CAPACITY+1];
	logic [31:0]         ch_stamp  [CAPACITY+1];

	// Reduced results of the row.
	logic                         any_hit;
	logic [kvt_pkg::SlotBits-1:0] hit_slot;
	logic signed [31:0]           hit_value;
	logic [31:0]                  hit_stamp;
	logic [KEY_BITS-1:0]          tail_key;
	logic signed [31:0]           tail_value;
	logic [31:0]                  tail_stamp;

	assign accept   = req.valid && req.ready;
	assign req.ready = state_q == kvt_pkg::ST_IDLE;
	assign out_free = !out_valid_q || rsp.ready;
	assign list_end = (kvt_pkg::CountBits'(list_idx_q) + 7'd1) == count_q;

	// Capture the request; the key is cut to the stored width.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= kvt_pkg::func_t'(req.func);
			key_q   <= req.key[KEY_BITS-1:0];
			value_q <= req.value;
			now_q   <= req.now;
		end
	end

	// The row of cells; the read-out chain ends in zeros past the last cell.
	assign ch_key[CAPACITY]   = '0;
	assign ch_value[CAPACITY] = '0;
	assign ch_stamp[CAPACITY] = '0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		kvt_cell #(
			.KEY_BITS (KEY_BITS),
			.SLOT     (g)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.req_key    (key_q),
			.req_value  (value_q),
			.req_now    (now_q),
			.count      (count_q),
			.tail_key   (tail_key),
			.tail_value (tail_value),
			.tail_stamp (tail_stamp),
			.nxt_key    (ch_key[g+1]),
			.nxt_value  (ch_value[g+1]),
			.nxt_stamp  (ch_stamp[g+1]),
			.hit        (hit_vec[g]),
			.is_tail    (tail_vec[g]),
			.ent_key    (ent_key[g]),
			.ent_value  (ent_value[g]),
			.ent_stamp  (ent_stamp[g]),
			.ch_key     (ch_key[g]),
			.ch_value   (ch_value[g]),
			.ch_stamp   (ch_stamp[g])
		);
	end

	// Live keys are unique, so at most one cell hits and an OR over the row selects it.
	// Exactly one cell is the tail when the table is not empty.
	assign any_hit = |hit_vec;

	always_comb begin
		hit_slot   = '0;
		hit_value  = '0;
		hit_stamp  = '0;
		tail_key   = '0;
		tail_value = '0;
		tail_stamp = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit_vec[i]) begin
				hit_slot  = hit_slot | kvt_pkg::SlotBits'(i);
				hit_value = hit_value | ent_value[i];
				hit_stamp = hit_stamp | ent_stamp[i];
			end
			if (tail_vec[i]) begin
				tail_key   = tail_key | ent_key[i];
				tail_value = tail_value | ent_value[i];
				tail_stamp = tail_stamp | ent_stamp[i];
			end
		end
	end

	// Sequencer state and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= kvt_pkg::ST_IDLE;
			count_q    <= '0;
			list_idx_q <= '0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			list_idx_q <= list_idx_d;
		end
	end

	// Next state, cell commands and the response to load.
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		list_idx_d   = list_idx_q;
		cmd          = '0;
		out_load     = 1'b0;
		out_status_d = kvt_pkg::STATUS_OK;
		out_value_d  = '0;
		out_slot_d   = '0;
		out_stamp_d  = '0;
		out_key_d    = 64'(key_q);
		out_count_d  = count_q;
		out_last_d   = 1'b1;
		unique case (state_q)
			kvt_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = kvt_pkg::ST_EXEC;
				end
			end
			kvt_pkg::ST_EXEC: begin
				if (func_q == kvt_pkg::FUNC_LIST) begin
					if (count_q != '0) begin
						cmd.list_load = 1'b1;
						list_idx_d    = '0;
						state_d       = kvt_pkg::ST_LIST;
					end else if (out_free) begin
						out_load     = 1'b1;
						out_status_d = kvt_pkg::STATUS_EMPTY;
						out_key_d    = '0;
						out_count_d  = '0;
						state_d      = kvt_pkg::ST_IDLE;
					end
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = kvt_pkg::ST_IDLE;
					case (func_q) inside
						kvt_pkg::FUNC_SET: begin
							if (any_hit) begin
								cmd.upd     = 1'b1;
								out_value_d = value_q;
								out_slot_d  = hit_slot;
								out_stamp_d = now_q;
							end else if (count_q < CapCount) begin
								cmd.append  = 1'b1;
								count_d     = count_q + 7'd1;
								out_value_d = value_q;
								out_slot_d  = count_q[kvt_pkg::SlotBits-1:0];
								out_stamp_d = now_q;
								out_count_d = count_q + 7'd1;
							end else begin
								out_status_d = kvt_pkg::STATUS_FULL;
							end
						end
						kvt_pkg::FUNC_GET, kvt_pkg::FUNC_DELETE: begin
							if (any_hit) begin
								out_value_d = hit_value;
								out_slot_d  = hit_slot;
								out_stamp_d = hit_stamp;
								if (func_q == kvt_pkg::FUNC_DELETE) begin
									cmd.del     = 1'b1;
									count_d     = count_q - 7'd1;
									out_count_d = count_q - 7'd1;
								end
							end else begin
								out_status_d = kvt_pkg::STATUS_NOT_FOUND;
							end
						end
						default: begin
							out_load = 1'b0;
						end
					endcase
				end
			end
			kvt_pkg::ST_LIST: begin
				if (out_free) begin
					out_load       = 1'b1;
					cmd.list_shift = 1'b1;
					out_value_d    = ch_value[0];
					out_slot_d     = list_idx_q;
					out_stamp_d    = ch_stamp[0];
					out_key_d      = 64'(ch_key[0]);
					out_last_d     = list_end;
					list_idx_d     = list_idx_q + 6'd1;
					if (list_end) begin
						state_d = kvt_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = kvt_pkg::ST_IDLE;
			end
		endcase
	end

	// Output register: loaded when free, emptied when the consumer takes the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= out_status_d;
			out_value_q  <= out_value_d;
			out_slot_q   <= out_slot_d;
			out_stamp_q  <= out_stamp_d;
			out_key_q    <= out_key_d;
			out_count_q  <= out_count_d;
			out_last_q   <= out_last_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.result_value = out_value_q;
	assign rsp.slot         = out_slot_q;
	assign rsp.stamp        = out_stamp_q;
	assign rsp.result_key   = out_key_q;
	assign rsp.count        = out_count_q;
	assign rsp.last         = out_last_q;

	// The count never runs past the capacity of the row.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CapCount)
		else $error("entry count exceeds capacity");

	// While a request is being looked up, at most one live cell matches its key.
	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kvt_pkg::ST_EXEC |-> $onehot0(hit_vec))
		else $error("more than one cell matches the key");

	// A committed delete removes exactly one entry.
	a_delete_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del |=> count_q == $past(count_q) - 7'd1)
		else $error("delete did not decrement the count");

	// A list in progress never starts on an empty table.
	a_list_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kvt_pkg::ST_LIST |-> count_q != '0)
		else $error("list running on an empty table");

endmodule

// ----- hw/rtl/kvt_cell.sv -----
`timescale 1ns / 1ps
// One cell of the table: holds the entry of one slot, compares it with the request key
// and carries one stage of the list read-out chain. Depends on kvt_pkg.
module kvt_cell #(
	parameter int KEY_BITS = 64,
	parameter int SLOT     = 0
) (
	input  logic                             clk,
	input  kvt_pkg::cell_cmd_t               cmd,
	input  logic [KEY_BITS-1:0]              req_key,
	input  logic signed [31:0]               req_value,
	input  logic [31:0]                      req_now,
	input  logic [kvt_pkg::CountBits-1:0]    count,
	input  logic [KEY_BITS-1:0]              tail_key,
	input  logic signed [31:0]               tail_value,
	input  logic [31:0]                      tail_stamp,
	input  logic [KEY_BITS-1:0]              nxt_key,
	input  logic signed [31:0]               nxt_value,
	input  logic [31:0]                      nxt_stamp,
	output logic                             hit,
	output logic                             is_tail,
	output logic [KEY_BITS-1:0]              ent_key,
	output logic signed [31:0]               ent_value,
	output logic [31:0]                      ent_stamp,
	output logic [KEY_BITS-1:0]              ch_key,
	output logic signed [31:0]               ch_value,
	output logic [31:0]                      ch_stamp
);

	localparam logic [kvt_pkg::CountBits-1:0] SlotIdx = kvt_pkg::CountBits'(SLOT);

	logic [KEY_BITS-1:0] key_q;
	logic signed [31:0]  value_q;
	logic [31:0]         stamp_q;
	logic [KEY_BITS-1:0] ch_key_q;
	logic signed [31:0]  ch_value_q;
	logic [31:0]         ch_stamp_q;
	logic                live;
	logic                at_free;

	// Only slots below the count hold live entries.
	assign live    = SlotIdx < count;
	assign hit     = live && (key_q == req_key);
	assign at_free = SlotIdx == count;
	assign is_tail = (SlotIdx + 7'd1) == count;

	// Entry storage: set writes the request, delete pulls in the tail entry.
	always_ff @(posedge clk) begin
		if ((cmd.upd && hit) || (cmd.append && at_free)) begin
			key_q   <= req_key;
			value_q <= req_value;
			stamp_q <= req_now;
		end else if (cmd.del && hit && !is_tail) begin
			key_q   <= tail_key;
			value_q <= tail_value;
			stamp_q <= tail_stamp;
		end
	end

	// Read-out chain stage: loaded from the entry, then shifted towards slot zero.
	always_ff @(posedge clk) begin
		if (cmd.list_load) begin
			ch_key_q   <= key_q;
			ch_value_q <= value_q;
			ch_stamp_q <= stamp_q;
		end else if (cmd.list_shift) begin
			ch_key_q   <= nxt_key;
			ch_value_q <= nxt_value;
			ch_stamp_q <= nxt_stamp;
		end
	end

	assign ent_key   = key_q;
	assign ent_value = value_q;
	assign ent_stamp = stamp_q;
	assign ch_key    = ch_key_q;
	assign ch_value  = ch_value_q;
	assign ch_stamp  = ch_stamp_q;

endmodule
